// ----- hdl/box_sum_downsample_2x2_macros.svh -----
// Assertion helpers for the checker of the 2x2 box-sum block.
`ifndef BOX_SUM_DOWNSAMPLE_2X2_MACROS_SVH
`define BOX_SUM_DOWNSAMPLE_2X2_MACROS_SVH

// Next-cycle implication that is switched off while reset is high.
`define BSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define BSD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bsd_pkg.sv -----
`timescale 1ns / 1ps
package bsd_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_PIXEL_BITS = 16;

  // Width of the size registers and of the row and column counters.
  localparam int CNT_BITS  = 12;
  localparam int ROW_LIMIT = 2048;
  // The pair index never exceeds 11 bits, so the line store is capped here.
  localparam int LINE_CAP  = 2048;

  localparam int OPQ_DEPTH  = 4;
  localparam int RESQ_DEPTH = 4;

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAD    = 2'd2;

  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_EMIT  = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       last;
  } bsd_ctl_t;

  function automatic int line_depth(int max_width);
    int depth;
    depth = (max_width + 1) >> 1;
    if (depth > LINE_CAP) depth = LINE_CAP;
    return depth;
  endfunction

  function automatic int line_addr_bits(int max_width);
    int depth;
    depth = line_depth(max_width);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- hdl/box_sum_downsample_2x2.sv -----
`timescale 1ns / 1ps
// Streams one image in raster order, one pixel per clock while full is low, and returns
// the sum of every 2x2 block in raster order of the reduced image; last_of_image marks the
// final block. The sustained rate is one pixel per cycle while results are popped, set by
// the single-port line store that holds the pair sums of the even row: each pixel needs at
// most one access to it. A block sum reaches the result ports through a four-entry op
// queue, a read stage and a four-entry result queue, so either side may stall without
// stopping the other until a queue fills. The line store needs no clearing after reset.
// Configuration writes restart the image and are taken at any time.
module box_sum_downsample_2x2 #(
  parameter int MAX_WIDTH  = bsd_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = bsd_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [PIXEL_BITS-1:0]             pixel_in,
  output logic                              empty,
  input  logic                              pop,
  output logic [PIXEL_BITS+1:0]             block_sum,
  output logic                              last_of_image,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bsd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bsd_pkg::CNT_BITS-1:0]      cfg_data
);

  localparam int AW  = bsd_pkg::line_addr_bits(MAX_WIDTH);
  localparam int CW  = $bits(bsd_pkg::bsd_ctl_t);
  localparam int OPW = CW + AW + PIXEL_BITS + 1;
  localparam int RW  = PIXEL_BITS + 3;

  logic                  in_accept;
  logic                  f_valid;
  bsd_pkg::bsd_ctl_t     f_ctl;
  logic [AW-1:0]         f_addr;
  logic [PIXEL_BITS:0]   f_pair;

  logic                  opq_empty;
  logic [OPW-1:0]        opq_head;
  bsd_pkg::bsd_ctl_t     b_ctl;
  logic [AW-1:0]         b_addr;
  logic [PIXEL_BITS:0]   b_pair;
  logic                  b_pop;

  logic                  res_wr;
  logic [PIXEL_BITS+1:0] res_sum;
  logic                  res_last;
  logic [RW-1:0]         resq_head;
  logic [$clog2(bsd_pkg::RESQ_DEPTH):0] res_count;

  assign cfg_ready = 1'b1;
  assign in_accept = push && !full;

  bsd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_accept),
    .pixel     (pixel_in),
    .op_valid  (f_valid),
    .op_ctl    (f_ctl),
    .op_addr   (f_addr),
    .op_pair   (f_pair)
  );

  bsd_fifo #(
    .WIDTH (OPW),
    .DEPTH (bsd_pkg::OPQ_DEPTH)
  ) u_opq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_valid),
    .wr_data ({f_ctl, f_addr, f_pair}),
    .full    (full),
    .rd_en   (b_pop),
    .rd_data (opq_head),
    .empty   (opq_empty),
    .count   ()
  );

  assign b_ctl  = opq_head[OPW-1 -: CW];
  assign b_addr = opq_head[PIXEL_BITS+1 +: AW];
  assign b_pair = opq_head[PIXEL_BITS:0];

  bsd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_avail  (!opq_empty),
    .op_ctl    (b_ctl),
    .op_addr   (b_addr),
    .op_pair   (b_pair),
    .op_pop    (b_pop),
    .res_count (res_count),
    .res_wr    (res_wr),
    .res_sum   (res_sum),
    .res_last  (res_last)
  );

  bsd_fifo #(
    .WIDTH (RW),
    .DEPTH (bsd_pkg::RESQ_DEPTH)
  ) u_resq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data ({res_last, res_sum}),
    .full    (),
    .rd_en   (pop),
    .rd_data (resq_head),
    .empty   (empty),
    .count   (res_count)
  );

  assign block_sum     = resq_head[PIXEL_BITS+1:0];
  assign last_of_image = resq_head[RW-1];

endmodule

// ----- hdl/bsd_fifo.sv -----
`timescale 1ns / 1ps
module bsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == ($clog2(DEPTH)+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/bsd_front.sv -----
`timescale 1ns / 1ps
module bsd_front #(
  parameter int MAX_WIDTH  = bsd_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = bsd_pkg::DEF_PIXEL_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr,
  input  logic [bsd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [bsd_pkg::CNT_BITS-1:0]           cfg_data,
  input  logic                                   in_valid,
  input  logic [PIXEL_BITS-1:0]                  pixel,
  output logic                                   op_valid,
  output bsd_pkg::bsd_ctl_t                      op_ctl,
  output logic [bsd_pkg::line_addr_bits(MAX_WIDTH)-1:0] op_addr,
  output logic [PIXEL_BITS:0]                    op_pair
);

  localparam int CB   = bsd_pkg::CNT_BITS;
  localparam int AW   = bsd_pkg::line_addr_bits(MAX_WIDTH);
  localparam int WCAP = (MAX_WIDTH > (1 << CB) - 1) ? (1 << CB) - 1 : MAX_WIDTH;

  logic [CB-1:0]         img_width;
  logic [CB-1:0]         img_height;
  logic                  pad_odd;
  logic [CB-1:0]         col_count;
  logic [CB-1:0]         row_count;
  logic [PIXEL_BITS-1:0] held_pixel;

  logic          cfg_hit;
  logic [CB-1:0] w1, w, h1, h, c, r, p;
  logic [CB-1:0] out_w, out_h;
  logic          last_col, last_row;
  logic          have_pair, hold_en, op_hit;
  logic [1:0]    kind;
  logic          last_blk;

  assign cfg_hit = cfg_wr && (cfg_index == bsd_pkg::CFG_WIDTH ||
                              cfg_index == bsd_pkg::CFG_HEIGHT ||
                              cfg_index == bsd_pkg::CFG_PAD);

  // Sizes of zero count as one; oversize values saturate.
  assign w1 = (img_width == '0) ? CB'(1) : img_width;
  assign w  = (w1 > CB'(WCAP)) ? CB'(WCAP) : w1;
  assign h1 = (img_height == '0) ? CB'(1) : img_height;
  assign h  = (h1 > CB'(bsd_pkg::ROW_LIMIT)) ? CB'(bsd_pkg::ROW_LIMIT) : h1;

  assign c = (col_count >= w) ? w - CB'(1) : col_count;
  assign r = (row_count >= h) ? h - CB'(1) : row_count;
  assign p = c >> 1;

  assign last_col = (c == w - CB'(1));
  assign last_row = (r == h - CB'(1));

  assign out_w = pad_odd ? CB'(({1'b0, w} + (CB+1)'(1)) >> 1) : (w >> 1);
  assign out_h = pad_odd ? CB'(({1'b0, h} + (CB+1)'(1)) >> 1) : (h >> 1);

  assign last_blk = (({1'b0, p} + (CB+1)'(1)) == {1'b0, out_w}) &&
                    (({1'b0, r >> 1} + (CB+1)'(1)) == {1'b0, out_h});

  always_comb begin
    have_pair = 1'b0;
    hold_en   = 1'b0;
    op_pair   = '0;
    if (!c[0]) begin
      if (last_col) begin
        if (pad_odd) begin
          op_pair   = {1'b0, pixel};
          have_pair = 1'b1;
        end
      end else begin
        hold_en = 1'b1;
      end
    end else begin
      op_pair   = {1'b0, held_pixel} + {1'b0, pixel};
      have_pair = 1'b1;
    end
  end

  // Even rows other than the last park their pair sums; odd rows and a padded even last row produce output.
  always_comb begin
    op_hit = 1'b0;
    kind   = bsd_pkg::OP_STORE;
    if (have_pair) begin
      if (!r[0]) begin
        if (last_row) begin
          if (pad_odd) begin
            op_hit = 1'b1;
            kind   = bsd_pkg::OP_EMIT;
          end
        end else begin
          op_hit = 1'b1;
          kind   = bsd_pkg::OP_STORE;
        end
      end else begin
        op_hit = 1'b1;
        kind   = bsd_pkg::OP_ADD;
      end
    end
  end

  assign op_valid    = in_valid && op_hit;
  assign op_ctl.kind = kind;
  assign op_ctl.last = last_blk;
  assign op_addr     = p[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= CB'(256);
      img_height <= CB'(256);
      pad_odd    <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_index)
        bsd_pkg::CFG_WIDTH:  img_width  <= cfg_data;
        bsd_pkg::CFG_HEIGHT: img_height <= cfg_data;
        bsd_pkg::CFG_PAD:    pad_odd    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_count  <= '0;
      row_count  <= '0;
      held_pixel <= '0;
    end else if (in_valid) begin
      if (hold_en) begin
        held_pixel <= pixel;
      end
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : r + CB'(1);
      end else begin
        col_count <= c + CB'(1);
        row_count <= r;
      end
    end
  end

endmodule

// ----- hdl/bsd_back.sv -----
`timescale 1ns / 1ps
module bsd_back #(
  parameter int MAX_WIDTH  = bsd_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = bsd_pkg::DEF_PIXEL_BITS
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           op_avail,
  input  bsd_pkg::bsd_ctl_t                              op_ctl,
  input  logic [bsd_pkg::line_addr_bits(MAX_WIDTH)-1:0]  op_addr,
  input  logic [PIXEL_BITS:0]                            op_pair,
  output logic                                           op_pop,
  input  logic [$clog2(bsd_pkg::RESQ_DEPTH):0]           res_count,
  output logic                                           res_wr,
  output logic [PIXEL_BITS+1:0]                          res_sum,
  output logic                                           res_last
);

  localparam int AW    = bsd_pkg::line_addr_bits(MAX_WIDTH);
  localparam int DEPTH = bsd_pkg::line_depth(MAX_WIDTH);

  logic [PIXEL_BITS:0] line_mem [DEPTH];
  logic [PIXEL_BITS:0] rd_q;
  logic                s2_valid;
  logic                s2_add;
  logic                s2_last;
  logic [PIXEL_BITS:0] s2_pair;
  logic                issue;
  logic                emits;

  // An op issues only if the result queue can still take what is in flight.
  assign issue  = op_avail &&
                  ((int'(res_count) + int'(s2_valid)) < bsd_pkg::RESQ_DEPTH);
  assign op_pop = issue;

  always_comb begin
    case (op_ctl.kind)
      bsd_pkg::OP_EMIT: emits = 1'b1;
      bsd_pkg::OP_ADD:  emits = 1'b1;
      default:          emits = 1'b0;
    endcase
  end

  // Every entry is written on an even row before the odd row below reads it.
  always_ff @(posedge clk) begin
    if (issue) begin
      if (op_ctl.kind == bsd_pkg::OP_STORE) begin
        line_mem[op_addr] <= op_pair;
      end
      rd_q <= line_mem[op_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s2_add  <= (op_ctl.kind == bsd_pkg::OP_ADD);
      s2_last <= op_ctl.last;
      s2_pair <= op_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= issue && emits;
    end
  end

  assign res_wr   = s2_valid;
  assign res_last = s2_last;
  assign res_sum  = s2_add ? {1'b0, rd_q} + {1'b0, s2_pair} : {1'b0, s2_pair};

endmodule

// ----- hdl/bsd_checker.sv -----
`timescale 1ns / 1ps
`include "box_sum_downsample_2x2_macros.svh"

module bsd_checker #(
  parameter int PIXEL_BITS = bsd_pkg::DEF_PIXEL_BITS
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  push,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input logic [PIXEL_BITS+1:0] block_sum,
  input logic                  last_of_image
);

  // A result shows up only after passing the op queue, the read stage and the result queue.
  `BSD_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, empty ##1 empty,
    "result after reset too early")

  `BSD_ASSERT_NEXT_ALWAYS(a_reset_room, clk, rst, !full, "input full after reset")

  `BSD_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop,
    !empty && $stable(block_sum) && $stable(last_of_image), "waiting result changed")

  // With the result queue empty and no push, an op queue that has room keeps room for a pixel.
  `BSD_ASSERT_NEXT(a_no_full_when_idle, clk, rst, empty && !full && !push, !full,
    "input blocked while idle")

endmodule

bind box_sum_downsample_2x2 bsd_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_bsd_checker (
  .clk           (clk),
  .rst           (rst),
  .push          (push),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .block_sum     (block_sum),
  .last_of_image (last_of_image)
);
